FILE: rtl/hirb_pkg.sv
// hirb_pkg: shared types and constants for the HID input report builder.
// Depends on nothing; every rtl file refers to it by scoped names.

package hirb_pkg;

	localparam int KEY_SLOTS     = 6;
	localparam int CONS_SLOTS    = 4;
	localparam int KEY_RPT_SLOTS = (KEY_SLOTS < 6) ? KEY_SLOTS : 6;

	localparam int KEY_W   = 8;
	localparam int USAGE_W = 16;
	localparam int KEYS_W  = 48;

	typedef enum logic [3:0] {
		OP_KB_PRESS     = 4'd0,
		OP_KB_RELEASE   = 4'd1,
		OP_KB_REL_ALL   = 4'd2,
		OP_MOVE         = 4'd3,
		OP_BTN_PRESS    = 4'd4,
		OP_BTN_RELEASE  = 4'd5,
		OP_SCROLL       = 4'd6,
		OP_CONS_PRESS   = 4'd7,
		OP_CONS_RELEASE = 4'd8,
		OP_CONS_REL_ALL = 4'd9,
		OP_MOUNT        = 4'd10,
		OP_UNMOUNT      = 4'd11,
		OP_HOST_OUT     = 4'd12
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_KEYBOARD = 2'd1,
		KIND_MOUSE    = 2'd2,
		KIND_CONSUMER = 2'd3
	} kind_t;

	localparam logic [7:0] LED_REPORT_ID = 8'd1;

	// Per-beat command broadcast to every key cell.
	typedef struct packed {
		logic             press;
		logic             release_key;
		logic             clear;
		logic [KEY_W-1:0] code;
	} key_ctl_t;

	// Per-beat command broadcast to every consumer cell.
	typedef struct packed {
		logic               press;
		logic               release_usage;
		logic               clear;
		logic [USAGE_W-1:0] usage;
	} cons_ctl_t;

endpackage

FILE: rtl/hirb_key_cell.sv
// hirb_key_cell: one keyboard key slot of the packed key row.
// Depends on hirb_pkg; neighbors link through the free, match and shift chains.

module hirb_key_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hirb_pkg::key_ctl_t            ctl,
	input  logic                          dup_any,
	input  logic                          free_seen_in,
	output logic                          free_seen_out,
	input  logic                          match_seen_in,
	output logic                          match_seen_out,
	input  logic [hirb_pkg::KEY_W-1:0]    right_val,
	output logic [hirb_pkg::KEY_W-1:0]    val,
	output logic [hirb_pkg::KEY_W-1:0]    nxt,
	output logic                          hit
);

	logic [hirb_pkg::KEY_W-1:0] val_q;
	logic                       is_free;
	logic                       is_match;

	assign val            = val_q;
	assign is_free        = (val_q == '0);
	assign is_match       = (val_q == ctl.code);
	assign hit            = is_match && !is_free;
	assign free_seen_out  = free_seen_in | is_free;
	assign match_seen_out = match_seen_in | is_match;

	always_comb begin
		nxt = val_q;
		if (ctl.clear) begin
			nxt = '0;
		end else if (ctl.press) begin
			// take the code in the first free slot only
			if (!dup_any && is_free && !free_seen_in)
				nxt = ctl.code;
		end else if (ctl.release_key) begin
			// from the released key onward, shift left by one
			if (match_seen_out)
				nxt = right_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			val_q <= '0;
		else
			val_q <= nxt;
	end

endmodule

FILE: rtl/hirb_cons_cell.sv
// hirb_cons_cell: one consumer-usage slot of the consumer row.
// Depends on hirb_pkg; neighbors link through the free and active-usage chains.

module hirb_cons_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hirb_pkg::cons_ctl_t           ctl,
	input  logic                          dup_any,
	input  logic                          free_seen_in,
	output logic                          free_seen_out,
	input  logic [hirb_pkg::USAGE_W-1:0]  act_in,
	output logic [hirb_pkg::USAGE_W-1:0]  act_out,
	output logic                          hit
);

	logic [hirb_pkg::USAGE_W-1:0] val_q;
	logic [hirb_pkg::USAGE_W-1:0] nxt;
	logic                         is_free;

	assign is_free       = (val_q == '0);
	assign hit           = (val_q == ctl.usage);
	assign free_seen_out = free_seen_in | is_free;

	always_comb begin
		nxt = val_q;
		if (ctl.clear) begin
			nxt = '0;
		end else if (ctl.press) begin
			if (!dup_any && is_free && !free_seen_in)
				nxt = ctl.usage;
		end else if (ctl.release_usage) begin
			if (hit)
				nxt = '0;
		end
	end

	// highest-index nonzero slot wins
	assign act_out = (nxt != '0) ? nxt : act_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			val_q <= '0;
		else
			val_q <= nxt;
	end

endmodule

FILE: rtl/hid_input_report_builder_core.sv
// hid_input_report_builder_core: top level of the HID input report builder.
// Depends on hirb_pkg, hirb_key_cell and hirb_cons_cell.
// Each report beat is registered and appears on the master side in the cycle after its event beat is accepted.
// Throughput: one event per cycle while the output beat is taken; the key and
// consumer cell rows settle one event per clock, and a single output register holds the report.
// Reset: arst_n low clears every held key, modifier, button, usage, LED and mount bit.

module hid_input_report_builder_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [7:0] key_code, [15:8] modifier_bits, [23:16] button_bits, [31:24] move_x,
	// [39:32] move_y, [47:40] wheel_delta, [63:48] consumer_usage, [71:64] led_bits,
	// [79:72] host_report_id, [86:80] host_report_length, [87] endpoint_ready
	input  logic [87:0]  s_tdata,
	// [3:0] operation
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] sent, [8:1] report_modifiers, [56:9] report_keys, [64:57] report_buttons,
	// [72:65] report_dx, [80:73] report_dy, [88:81] report_wheel,
	// [104:89] report_usage, [105] connected, [113:106] host_leds, [119:114] zero
	output logic [119:0] m_tdata,
	// [1:0] report_kind
	output logic [1:0]   m_tuser
);

	localparam int KS = hirb_pkg::KEY_SLOTS;
	localparam int CS = hirb_pkg::CONS_SLOTS;

	// Unpack the event beat.
	hirb_pkg::op_t                 op;
	logic [7:0]                    key_code;
	logic [7:0]                    modifier_bits;
	logic [7:0]                    button_bits;
	logic [7:0]                    move_x;
	logic [7:0]                    move_y;
	logic [7:0]                    wheel_delta;
	logic [hirb_pkg::USAGE_W-1:0]  consumer_usage;
	logic [7:0]                    led_bits;
	logic [7:0]                    host_report_id;
	logic [6:0]                    host_report_length;
	logic                          endpoint_ready;

	assign op                 = hirb_pkg::op_t'(s_tuser);
	assign key_code           = s_tdata[7:0];
	assign modifier_bits      = s_tdata[15:8];
	assign button_bits        = s_tdata[23:16];
	assign move_x             = s_tdata[31:24];
	assign move_y             = s_tdata[39:32];
	assign wheel_delta        = s_tdata[47:40];
	assign consumer_usage     = s_tdata[63:48];
	assign led_bits           = s_tdata[71:64];
	assign host_report_id     = s_tdata[79:72];
	assign host_report_length = s_tdata[86:80];
	assign endpoint_ready     = s_tdata[87];

	// Handshake: the output register frees up when its beat is taken.
	logic accept;
	logic m_valid_q;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Scalar state.
	logic [7:0] mod_q, btn_q, led_q;
	logic       mnt_q;
	logic [7:0] mod_nxt, btn_nxt, led_nxt;
	logic       mnt_nxt;

	hirb_pkg::kind_t     kind;
	logic [7:0]          dx, dy, dw;
	hirb_pkg::key_ctl_t  key_ctl;
	hirb_pkg::cons_ctl_t cons_ctl;

	// Decode one event: scalar next state, the report kind and the row commands.
	always_comb begin
		mod_nxt  = mod_q;
		btn_nxt  = btn_q;
		led_nxt  = led_q;
		mnt_nxt  = mnt_q;
		kind     = hirb_pkg::KIND_NONE;
		dx       = '0;
		dy       = '0;
		dw       = '0;
		key_ctl  = '{press: 1'b0, release_key: 1'b0, clear: 1'b0, code: key_code};
		cons_ctl = '{press: 1'b0, release_usage: 1'b0, clear: 1'b0, usage: consumer_usage};
		if (accept) begin
			case (op)
				hirb_pkg::OP_KB_PRESS: begin
					mod_nxt       = mod_q | modifier_bits;
					key_ctl.press = (key_code != '0);
					kind          = hirb_pkg::KIND_KEYBOARD;
				end
				hirb_pkg::OP_KB_RELEASE: begin
					mod_nxt             = mod_q & ~modifier_bits;
					key_ctl.release_key = (key_code != '0);
					kind                = hirb_pkg::KIND_KEYBOARD;
				end
				hirb_pkg::OP_KB_REL_ALL: begin
					mod_nxt       = '0;
					key_ctl.clear = 1'b1;
					kind          = hirb_pkg::KIND_KEYBOARD;
				end
				hirb_pkg::OP_MOVE: begin
					dx   = move_x;
					dy   = move_y;
					kind = hirb_pkg::KIND_MOUSE;
				end
				hirb_pkg::OP_BTN_PRESS: begin
					btn_nxt = btn_q | button_bits;
					kind    = hirb_pkg::KIND_MOUSE;
				end
				hirb_pkg::OP_BTN_RELEASE: begin
					btn_nxt = btn_q & ~button_bits;
					kind    = hirb_pkg::KIND_MOUSE;
				end
				hirb_pkg::OP_SCROLL: begin
					dw   = wheel_delta;
					kind = hirb_pkg::KIND_MOUSE;
				end
				hirb_pkg::OP_CONS_PRESS: begin
					cons_ctl.press = (consumer_usage != '0);
					kind           = hirb_pkg::KIND_CONSUMER;
				end
				hirb_pkg::OP_CONS_RELEASE: begin
					cons_ctl.release_usage = 1'b1;
					kind                   = hirb_pkg::KIND_CONSUMER;
				end
				hirb_pkg::OP_CONS_REL_ALL: begin
					cons_ctl.clear = 1'b1;
					kind           = hirb_pkg::KIND_CONSUMER;
				end
				hirb_pkg::OP_MOUNT: begin
					mnt_nxt = 1'b1;
				end
				hirb_pkg::OP_UNMOUNT: begin
					// drop everything, LED byte included
					mnt_nxt        = 1'b0;
					mod_nxt        = '0;
					btn_nxt        = '0;
					led_nxt        = '0;
					key_ctl.clear  = 1'b1;
					cons_ctl.clear = 1'b1;
				end
				hirb_pkg::OP_HOST_OUT: begin
					if (host_report_id == hirb_pkg::LED_REPORT_ID && host_report_length != '0)
						led_nxt = led_bits;
				end
				default: begin
				end
			endcase
		end
	end

	// Key row: slot 0 on the left, freed slots fill from the right with zero.
	logic [hirb_pkg::KEY_W-1:0] key_val [KS+1];
	logic [hirb_pkg::KEY_W-1:0] key_nxt [KS];
	logic [KS:0]                key_free_chain;
	logic [KS:0]                key_match_chain;
	logic [KS-1:0]              key_hit;
	logic                       key_dup;

	assign key_val[KS]        = '0;
	assign key_free_chain[0]  = 1'b0;
	assign key_match_chain[0] = 1'b0;
	assign key_dup            = |key_hit;

	for (genvar i = 0; i < KS; i++) begin : g_key
		hirb_key_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (key_ctl),
			.dup_any        (key_dup),
			.free_seen_in   (key_free_chain[i]),
			.free_seen_out  (key_free_chain[i+1]),
			.match_seen_in  (key_match_chain[i]),
			.match_seen_out (key_match_chain[i+1]),
			.right_val      (key_val[i+1]),
			.val            (key_val[i]),
			.nxt            (key_nxt[i]),
			.hit            (key_hit[i])
		);
	end

	// Consumer row: the active-usage chain runs from slot 0 up to the last slot.
	logic [hirb_pkg::USAGE_W-1:0] cons_act [CS+1];
	logic [CS:0]                  cons_free_chain;
	logic [CS-1:0]                cons_hit;
	logic                         cons_dup;

	assign cons_act[0]        = '0;
	assign cons_free_chain[0] = 1'b0;
	assign cons_dup           = |cons_hit;

	for (genvar i = 0; i < CS; i++) begin : g_cons
		hirb_cons_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (cons_ctl),
			.dup_any       (cons_dup),
			.free_seen_in  (cons_free_chain[i]),
			.free_seen_out (cons_free_chain[i+1]),
			.act_in        (cons_act[i]),
			.act_out       (cons_act[i+1]),
			.hit           (cons_hit[i])
		);
	end

	// Pack the visible key slots, slot 0 in the low byte.
	logic [hirb_pkg::KEYS_W-1:0] keys_rpt;
	always_comb begin
		keys_rpt = '0;
		for (int i = 0; i < hirb_pkg::KEY_RPT_SLOTS; i++)
			keys_rpt[hirb_pkg::KEY_W*i +: hirb_pkg::KEY_W] = key_nxt[i];
	end

	logic sent;
	assign sent = (kind != hirb_pkg::KIND_NONE) && mnt_nxt && endpoint_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q     <= '0;
			btn_q     <= '0;
			led_q     <= '0;
			mnt_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			mod_q <= mod_nxt;
			btn_q <= btn_nxt;
			led_q <= led_nxt;
			mnt_q <= mnt_nxt;
			if (accept)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// Report register: load on each accepted event, hold while stalled.
	logic [119:0] rpt_data_q;
	logic [1:0]   rpt_kind_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			rpt_kind_q <= kind;
			rpt_data_q <= {6'd0, led_nxt, mnt_nxt, cons_act[CS], dw, dy, dx,
				btn_nxt, keys_rpt, mod_nxt, sent};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = rpt_data_q;
	assign m_tuser  = rpt_kind_q;

endmodule

FILE: rtl/hirb_checker.sv
// hirb_checker: port-level checks on hid_input_report_builder_core, with its bind.
// Depends on hirb_pkg for operation and report codes.

module hirb_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [87:0]  s_tdata,
	input  logic [3:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [119:0] m_tdata,
	input  logic [1:0]   m_tuser
);

	// a sent report is never kind none and only goes out while mounted
	a_sent_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (m_tuser != hirb_pkg::KIND_NONE) && m_tdata[105])
		else $error("sent report without kind or mount");

	// unmount leaves a disconnected, empty report
	a_unmount: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == hirb_pkg::OP_UNMOUNT |=>
		m_tvalid && !m_tdata[105] && m_tdata[104:1] == '0 && m_tdata[113:106] == '0)
		else $error("unmount did not clear state");

	// a move passes its deltas straight through
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == hirb_pkg::OP_MOVE |=>
		m_tvalid && m_tuser == hirb_pkg::KIND_MOUSE &&
		m_tdata[72:65] == $past(s_tdata[31:24]) && m_tdata[80:73] == $past(s_tdata[39:32]))
		else $error("move deltas lost");

	// a stalled report beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("report beat changed while stalled");

endmodule

bind hid_input_report_builder_core hirb_checker u_hirb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
